/* hw/rtl/xcrc_pkg.sv */
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver package
// Shared types, protocol byte codes, event and phase codes, and the CRC-16
// byte update used by the receiver.
// ----------------------------------------------------------------------------
package xcrc_pkg;

    // Frame geometry: SOH, packet number, complement, payload, two CRC bytes.
    localparam int PAYLOAD_BYTES = 128;
    localparam int FRAME_BYTES   = PAYLOAD_BYTES + 5;
    localparam int COUNT_W       = $clog2(FRAME_BYTES + 1);
    localparam int INDEX_W       = $clog2(PAYLOAD_BYTES);

    // Byte position markers inside a frame.
    localparam logic [COUNT_W-1:0] POS_SOH     = COUNT_W'(0);
    localparam logic [COUNT_W-1:0] POS_PKT     = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] POS_PKT_INV = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] POS_DATA    = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] POS_CRC_HI  = COUNT_W'(PAYLOAD_BYTES + 3);
    localparam logic [COUNT_W-1:0] POS_END     = COUNT_W'(FRAME_BYTES);

    // Protocol characters.
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_C   = 8'h43;

    // The packet number and its complement XOR to all ones.
    localparam logic [7:0] PKT_CHECK = 8'hff;

    // Input actions.
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;

    // Reported events.
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_ENTRY  = 3'd1;
    localparam logic [2:0] EV_DATA   = 3'd2;
    localparam logic [2:0] EV_ACCEPT = 3'd3;
    localparam logic [2:0] EV_END    = 3'd4;
    localparam logic [2:0] EV_CANCEL = 3'd5;
    localparam logic [2:0] EV_GAVEUP = 3'd6;

    // Configuration register indexes and reset values.
    localparam logic [1:0] REG_HS_INTERVAL = 2'd0;
    localparam logic [1:0] REG_FRAME_TMO   = 2'd1;
    localparam logic [1:0] REG_HS_LIMIT    = 2'd2;
    localparam logic [1:0] REG_NAK_LIMIT   = 2'd3;

    localparam logic [15:0] RST_HS_INTERVAL = 16'd1000;
    localparam logic [15:0] RST_FRAME_TMO   = 16'd1000;
    localparam logic [7:0]  RST_HS_LIMIT    = 8'd100;
    localparam logic [7:0]  RST_NAK_LIMIT   = 8'd50;

    typedef enum logic [1:0] {
        PH_STOP = 2'd0,
        PH_WAIT = 2'd1,
        PH_XFER = 2'd2
    } phase_t;

    // One input item.
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
    } item_t;

    // One result item.
    typedef struct packed {
        logic               send_valid;
        logic [7:0]         send_byte;
        logic [2:0]         event_res;
        logic [7:0]         data_byte;
        logic [INDEX_W-1:0] data_index;
        logic [7:0]         packet_number;
        logic [1:0]         phase;
    } result_t;

    // Item handed from the input register to the core.
    typedef struct packed {
        logic  fire;
        item_t item;
    } step_t;

    // CRC-16/XMODEM update by one byte.
    function automatic logic [15:0] crc_update(input logic [15:0] c_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = {c_in[7:0], c_in[15:8]};
        c = c ^ {8'h00, b};
        c = c ^ {12'h000, c[7:4]};
        c = c ^ {c[3:0], 12'h000};
        c = c ^ {3'b000, c[7:0], 5'b00000};
        return c;
    endfunction

endpackage

/* hw/rtl/xcrc_if.sv */
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver channels
// Valid/ready stream interfaces for input items and result items.
// ----------------------------------------------------------------------------
interface xcrc_in_if;
    logic           valid;
    logic           ready;
    xcrc_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface xcrc_out_if;
    logic             valid;
    logic             ready;
    xcrc_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/xcrc_in_stage.sv */
// ----------------------------------------------------------------------------
// XMODEM-CRC input register
// Holds one accepted item until the result register can take its result.
// ----------------------------------------------------------------------------
module xcrc_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    xcrc_in_if.sink          req,
    input  logic             take,
    output xcrc_pkg::step_t  step
);
    import xcrc_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // Room for a new item when empty or when the held item moves on.
    assign req.ready = !valid_reg || take;

    // Valid flag of the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.valid && req.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload of the input register.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg <= req.data;
        end
    end

    // The held item is processed in the cycle it moves on.
    assign step.fire = valid_reg && take;
    assign step.item = item_reg;

endmodule

/* hw/rtl/xcrc_core.sv */
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver core
// Configuration registers, receiver state and the single-pass step logic
// that turns one item into one result.
// ----------------------------------------------------------------------------
module xcrc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_wdata,
    input  xcrc_pkg::step_t   step,
    output xcrc_pkg::result_t result
);
    import xcrc_pkg::*;

    // Configuration.
    logic [15:0] hs_interval_reg;
    logic [15:0] frame_tmo_reg;
    logic [7:0]  hs_limit_reg;
    logic [7:0]  nak_limit_reg;

    // Receiver state.
    phase_t             phase_reg,      phase_next;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]         first_byte_reg, first_byte_next;
    logic [7:0]         pkt_reg,        pkt_next;
    logic [7:0]         pkt_inv_reg,    pkt_inv_next;
    logic [15:0]        crc_reg,        crc_next;
    logic [7:0]         crc_hi_reg,     crc_hi_next;
    logic [15:0]        tick_reg,       tick_next;
    logic [7:0]         hs_retry_reg,   hs_retry_next;
    logic [7:0]         nak_retry_reg,  nak_retry_next;

    // Step helpers.
    logic               waiting;
    logic [15:0]        tick_inc;
    logic [15:0]        limit_t;
    logic [7:0]         retries;
    logic [7:0]         limit_r;
    logic [7:0]         retries_inc;
    logic [COUNT_W-1:0] data_pos;
    logic [7:0]         rx;
    logic               frame_good;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hs_interval_reg <= RST_HS_INTERVAL;
            frame_tmo_reg   <= RST_FRAME_TMO;
            hs_limit_reg    <= RST_HS_LIMIT;
            nak_limit_reg   <= RST_NAK_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HS_INTERVAL: hs_interval_reg <= cfg_wdata;
                REG_FRAME_TMO:   frame_tmo_reg   <= cfg_wdata;
                REG_HS_LIMIT:    hs_limit_reg    <= cfg_wdata[7:0];
                REG_NAK_LIMIT:   nak_limit_reg   <= cfg_wdata[7:0];
                default:         ;
            endcase
        end
    end

    // Timer and retry selection by phase.
    assign rx          = step.item.rx_byte;
    assign waiting     = (phase_reg == PH_WAIT);
    assign tick_inc    = (tick_reg != '1) ? tick_reg + 16'd1 : tick_reg;
    assign limit_t     = waiting ? hs_interval_reg : frame_tmo_reg;
    assign retries     = waiting ? hs_retry_reg : nak_retry_reg;
    assign limit_r     = waiting ? hs_limit_reg : nak_limit_reg;
    assign retries_inc = (retries != '1) ? retries + 8'd1 : retries;
    assign data_pos    = byte_count_reg - POS_DATA;
    assign frame_good  = (first_byte_reg == CH_SOH)
                      && ((pkt_reg ^ pkt_inv_reg) == PKT_CHECK)
                      && ({crc_hi_reg, rx} == crc_reg);

    // Next state and result for the item in hand.
    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        first_byte_next = first_byte_reg;
        pkt_next        = pkt_reg;
        pkt_inv_next    = pkt_inv_reg;
        crc_next        = crc_reg;
        crc_hi_next     = crc_hi_reg;
        tick_next       = tick_reg;
        hs_retry_next   = hs_retry_reg;
        nak_retry_next  = nak_retry_reg;
        result          = '0;

        case (step.item.action)
            ACT_START:
            begin
                byte_count_next = '0;
                crc_next        = '0;
                first_byte_next = '0;
                pkt_next        = '0;
                pkt_inv_next    = '0;
                crc_hi_next     = '0;
                tick_next       = '0;
                hs_retry_next   = '0;
                nak_retry_next  = '0;
                phase_next      = PH_WAIT;
                result.event_res = EV_ENTRY;
            end
            ACT_TICK:
            begin
                if (phase_reg != PH_STOP)
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= limit_t)
                    begin
                        byte_count_next = '0;
                        crc_next        = '0;
                        if (retries > limit_r)
                        begin
                            phase_next       = PH_STOP;
                            result.event_res = EV_GAVEUP;
                        end
                        else
                        begin
                            if (waiting)
                            begin
                                hs_retry_next    = retries_inc;
                                result.send_byte = CH_C;
                            end
                            else
                            begin
                                nak_retry_next   = retries_inc;
                                result.send_byte = CH_NAK;
                            end
                            tick_next         = '0;
                            result.send_valid = 1'b1;
                        end
                    end
                end
            end
            ACT_BYTE:
            begin
                if (phase_reg != PH_STOP)
                begin
                    // End or cancel at a frame start while transferring.
                    if (byte_count_reg == POS_SOH && phase_reg == PH_XFER
                        && (rx == CH_EOT || rx == CH_CAN))
                    begin
                        byte_count_next = '0;
                        crc_next        = '0;
                        phase_next      = PH_STOP;
                        if (rx == CH_EOT)
                        begin
                            result.event_res  = EV_END;
                            result.send_valid = 1'b1;
                            result.send_byte  = CH_ACK;
                        end
                        else
                        begin
                            result.event_res = EV_CANCEL;
                        end
                    end
                    else if (byte_count_reg < POS_END)
                    begin
                        byte_count_next = byte_count_reg + COUNT_W'(1);
                        if (byte_count_reg == POS_SOH)
                        begin
                            first_byte_next = rx;
                            crc_next        = '0;
                        end
                        else if (byte_count_reg == POS_PKT)
                        begin
                            pkt_next = rx;
                        end
                        else if (byte_count_reg == POS_PKT_INV)
                        begin
                            pkt_inv_next = rx;
                        end
                        else if (byte_count_reg < POS_CRC_HI)
                        begin
                            crc_next          = crc_update(crc_reg, rx);
                            result.event_res  = EV_DATA;
                            result.data_byte  = rx;
                            result.data_index = data_pos[INDEX_W-1:0];
                        end
                        else if (byte_count_reg == POS_CRC_HI)
                        begin
                            crc_hi_next = rx;
                        end
                        else if (frame_good)
                        begin
                            // Last CRC byte of a good frame.
                            result.event_res     = EV_ACCEPT;
                            result.packet_number = pkt_reg;
                            result.send_valid    = 1'b1;
                            result.send_byte     = CH_ACK;
                            nak_retry_next       = '0;
                            tick_next            = '0;
                            phase_next           = PH_XFER;
                            byte_count_next      = '0;
                            crc_next             = '0;
                        end
                    end
                end
            end
            default:
            begin
                // Unused action code: no effect.
            end
        endcase

        result.phase = phase_next;
    end

    // State registers advance only when an item is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_STOP;
            byte_count_reg <= '0;
            first_byte_reg <= '0;
            pkt_reg        <= '0;
            pkt_inv_reg    <= '0;
            crc_reg        <= '0;
            crc_hi_reg     <= '0;
            tick_reg       <= '0;
            hs_retry_reg   <= '0;
            nak_retry_reg  <= '0;
        end
        else if (step.fire)
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            first_byte_reg <= first_byte_next;
            pkt_reg        <= pkt_next;
            pkt_inv_reg    <= pkt_inv_next;
            crc_reg        <= crc_next;
            crc_hi_reg     <= crc_hi_next;
            tick_reg       <= tick_next;
            hs_retry_reg   <= hs_retry_next;
            nak_retry_reg  <= nak_retry_next;
        end
    end

endmodule

/* hw/rtl/xcrc_out_stage.sv */
// ----------------------------------------------------------------------------
// XMODEM-CRC result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module xcrc_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  xcrc_pkg::step_t   step,
    input  xcrc_pkg::result_t result,
    output logic              take,
    xcrc_out_if.source        rsp
);
    import xcrc_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // A new result fits when empty or when the held one leaves now.
    assign take = !valid_reg || rsp.ready;

    // Valid flag of the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (step.fire)
        begin
            valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload of the result register.
    always_ff @(posedge clk)
    begin
        if (step.fire)
        begin
            data_reg <= result;
        end
    end

    assign rsp.valid = valid_reg;
    assign rsp.data  = data_reg;

endmodule

/* hw/rtl/xmodem_crc_receiver.sv */
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver
//
//   Channel  Direction  Handshake         Payload
//   req      in         req.valid/ready   action, rx_byte
//   rsp      out        rsp.valid/ready   send_valid .. phase
//   cfg      in         cfg_we            cfg_index, cfg_wdata
//
// One item per cycle is sustained while rsp.ready stays high; its result
// passes through the input register and then the result register.
// The whole step (CRC byte update, frame check, timers) is one pass of logic.
// Reset clears the receiver to stopped and loads the register defaults.
// A stalled output holds its result while the input register still takes
// one more item.
// ----------------------------------------------------------------------------
module xmodem_crc_receiver (
    input  logic        clk,
    input  logic        rst_n,
    xcrc_in_if.sink     req,
    xcrc_out_if.source  rsp,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import xcrc_pkg::*;

    step_t   step;
    result_t result;
    logic    take;

    // Input register.
    xcrc_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .take  (take),
        .step  (step)
    );

    // Receiver state and step logic.
    xcrc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .result    (result)
    );

    // Result register.
    xcrc_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .result (result),
        .take   (take),
        .rsp    (rsp)
    );

    // Only protocol characters are ever sent.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.send_valid) |->
        (rsp.data.send_byte == CH_C || rsp.data.send_byte == CH_ACK
         || rsp.data.send_byte == CH_NAK))
        else $error("send_byte is not a protocol character");

    // An accepted frame is answered with ACK and leaves the block transferring.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.event_res == EV_ACCEPT) |->
        (rsp.data.send_valid && rsp.data.send_byte == CH_ACK
         && rsp.data.phase == PH_XFER))
        else $error("accepted frame without ACK or transferring phase");

    // A start always reports waiting and sends nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.event_res == EV_ENTRY) |->
        (!rsp.data.send_valid && rsp.data.phase == PH_WAIT))
        else $error("entry event with wrong phase or a sent byte");

    // Data bytes are reported only while the receiver is not stopped, and send nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.event_res == EV_DATA) |->
        (rsp.data.phase != PH_STOP && !rsp.data.send_valid))
        else $error("data byte reported while stopped");

endmodule
